@@ design/size_class_block_allocator_top_macros.svh @@
// Assertion macros for the size-class block allocator.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/scba_pkg.sv @@
// Package: constants, codes and helpers of the size-class block allocator.
package scba_pkg;

  localparam int POOL_PAGES      = 64;
  localparam int PAGE_BYTES      = 4096;
  localparam int NUM_CLASSES     = 8;
  localparam int MIN_BLOCK_BYTES = 16;

  localparam int UNITS_PER_PAGE = PAGE_BYTES / MIN_BLOCK_BYTES;
  localparam int TOTAL_UNITS    = POOL_PAGES * UNITS_PER_PAGE;
  localparam int PAGE_W         = $clog2(POOL_PAGES);
  localparam int SLOT_W         = $clog2(UNITS_PER_PAGE);
  localparam int UNIT_W         = PAGE_W + SLOT_W;
  localparam int LINK_W         = UNIT_W + 1;
  localparam int NFP_W          = PAGE_W + 1;
  localparam int CLASS_W        = 3;
  localparam int OFS_LO         = $clog2(MIN_BLOCK_BYTES);
  localparam int OFS_HI         = $clog2(PAGE_BYTES) - 1;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNSUP     = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
  localparam logic [1:0] STATUS_UNMANAGED = 2'd3;

  typedef struct packed {
    logic                bad;
    logic [CLASS_W-1:0]  cls;
  } class_sel_t;

  function automatic class_sel_t size_to_class(input logic [15:0] size);
    class_sel_t r;
    r.bad = 1'b1;
    r.cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size <= 16'(MIN_BLOCK_BYTES << c)) begin
        r.bad = 1'b0;
        r.cls = CLASS_W'(c);
      end
    end
    if (size == 16'd0) r.bad = 1'b1;
    return r;
  endfunction

  function automatic logic [11:0] class_bytes(input logic [CLASS_W-1:0] c);
    return 12'(MIN_BLOCK_BYTES) << c;
  endfunction

endpackage

@@ design/scba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/size_class_block_allocator_top.sv @@
// Top level: segregated free-list allocator over a pool of pages.
//
// Usage: drive func, req_size and address with start high; the request
// transfers at the rising edge where start is high and busy is low. Exactly
// one result follows per request, shown for one cycle with done high on
// status, block_address and usable_bytes. The receiver cannot stall; the
// result is taken in the cycle done is high.
// Result paths after the transfer:
//   rejected requests (bad size or function, exhausted pool, unmanaged
//   page): done is registered straight from the idle state.
//   allocate from a nonempty list, free, query: one read of the link RAM or
//   the page-class RAM, then write-back.
//   allocate that carves a fresh page: one link write per slot but slot 0.
// A new request may transfer in the cycle its predecessor's done is high.
// Reset clears the list heads and the fresh-page counter; pages at or above
// the counter are unmanaged, so no RAM clearing pass runs.
module size_class_block_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] req_size,
  input  logic [17:0] address,
  output logic        done,
  output logic [1:0]  status,
  output logic [17:0] block_address,
  output logic [11:0] usable_bytes
);

  `include "size_class_block_allocator_top_macros.svh"

  localparam int PW = scba_pkg::PAGE_W;
  localparam int SW = scba_pkg::SLOT_W;
  localparam int UW = scba_pkg::UNIT_W;
  localparam int LW = scba_pkg::LINK_W;
  localparam int CW = scba_pkg::CLASS_W;

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_LOOKUP, ST_CARVE} state_t;

  state_t                      state;
  logic [LW-1:0]               heads [scba_pkg::NUM_CLASSES];
  logic [scba_pkg::NFP_W-1:0]  nfp;
  logic [CW-1:0]               cls;
  logic                        is_free;
  logic [PW-1:0]               page;
  logic [SW-1:0]               unit_ofs;
  logic [SW-1:0]               k;

  scba_pkg::class_sel_t        sel;
  logic                        accept;
  logic [LW-1:0]               head_in;
  logic [PW-1:0]               in_page;

  logic                        link_we;
  logic [UW-1:0]               link_waddr;
  logic [LW-1:0]               link_wdata;
  logic [UW-1:0]               link_raddr;
  logic [LW-1:0]               link_rdata;
  logic                        pc_we;
  logic [CW-1:0]               pc_rdata;

  logic [SW-1:0]               step;
  logic [SW-1:0]               last_k;
  logic [SW-1:0]               free_slot;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign sel      = scba_pkg::size_to_class(req_size);
  assign head_in  = heads[sel.cls];
  assign in_page  = address[17:17-PW+1];
  assign step     = SW'(1) << cls;
  assign last_k   = SW'((scba_pkg::UNITS_PER_PAGE >> cls) - 1);
  assign free_slot = unit_ofs & (SW'({SW{1'b1}}) << pc_rdata);

  assign pc_we = accept && (func == scba_pkg::FUNC_ALLOC) && !sel.bad &&
                 (head_in == '0) && (nfp < scba_pkg::NFP_W'(scba_pkg::POOL_PAGES));

  assign link_raddr = UW'(head_in - LW'(1));

  always_comb begin
    link_we    = 1'b0;
    link_waddr = {page, SW'(k << cls)};
    link_wdata = '0;
    if (state == ST_CARVE) begin
      link_we = 1'b1;
      if (k != last_k) link_wdata = LW'({page, SW'((k + SW'(1)) << cls)}) + LW'(1);
    end else if (state == ST_LOOKUP && is_free && free_slot != '0) begin
      link_we    = 1'b1;
      link_waddr = {page, free_slot};
      link_wdata = heads[pc_rdata];
    end
  end

  scba_ram #(.WIDTH(LW), .DEPTH(scba_pkg::TOTAL_UNITS)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  scba_ram #(.WIDTH(CW), .DEPTH(scba_pkg::POOL_PAGES)) u_page_class (
    .clk   (clk),
    .we    (pc_we),
    .waddr (nfp[PW-1:0]),
    .wdata (sel.cls),
    .raddr (in_page),
    .rdata (pc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nfp   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < scba_pkg::NUM_CLASSES; i++) heads[i] <= '0;
    end else begin
      done          <= 1'b0;
      status        <= scba_pkg::STATUS_OK;
      block_address <= '0;
      usable_bytes  <= '0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cls      <= sel.cls;
            page     <= (func == scba_pkg::FUNC_ALLOC) ? nfp[PW-1:0] : in_page;
            unit_ofs <= address[scba_pkg::OFS_HI:scba_pkg::OFS_LO];
            is_free  <= (func == scba_pkg::FUNC_FREE);
            if (func == scba_pkg::FUNC_ALLOC) begin
              if (sel.bad) begin
                done   <= 1'b1;
                status <= scba_pkg::STATUS_UNSUP;
              end else if (head_in != '0) begin
                state <= ST_POP;
              end else if (pc_we) begin
                k     <= SW'(1);
                state <= ST_CARVE;
              end else begin
                done   <= 1'b1;
                status <= scba_pkg::STATUS_EXHAUSTED;
              end
            end else if (func == scba_pkg::FUNC_FREE || func == scba_pkg::FUNC_QUERY) begin
              if (scba_pkg::NFP_W'(in_page) >= nfp) begin
                done   <= 1'b1;
                status <= scba_pkg::STATUS_UNMANAGED;
              end else begin
                state <= ST_LOOKUP;
              end
            end else begin
              done   <= 1'b1;
              status <= scba_pkg::STATUS_UNSUP;
            end
          end
        end
        ST_POP: begin
          heads[cls]    <= link_rdata;
          block_address <= 18'(heads[cls] - LW'(1)) << scba_pkg::OFS_LO;
          done          <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_LOOKUP: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (!is_free) begin
            usable_bytes <= scba_pkg::class_bytes(pc_rdata);
          end else if (free_slot == '0) begin
            status <= scba_pkg::STATUS_UNMANAGED;
          end else begin
            heads[pc_rdata] <= LW'({page, free_slot}) + LW'(1);
          end
        end
        ST_CARVE: begin
          k <= k + SW'(1);
          if (k == last_k) begin
            heads[cls]    <= (last_k > SW'(1)) ? LW'({page, SW'(step << 1)}) + LW'(1) : '0;
            block_address <= 18'({page, step}) << scba_pkg::OFS_LO;
            nfp           <= nfp + scba_pkg::NFP_W'(1);
            done          <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SCBA_ASSERT_IMP(a_blk_ok, done && block_address != '0, status == scba_pkg::STATUS_OK, "block without ok")
  `SCBA_ASSERT_IMP(a_use_ok, done && usable_bytes != '0, status == scba_pkg::STATUS_OK, "usable without ok")
  `SCBA_ASSERT_IMP(a_nfp_max, 1'b1, nfp <= scba_pkg::NFP_W'(scba_pkg::POOL_PAGES), "page counter past pool")
  `SCBA_ASSERT_NXT(a_carve_end, state == ST_CARVE, state == ST_CARVE || done, "carve ended without result")

endmodule

@@ sim/tb_size_class_block_allocator_top.sv @@
// Testbench: drives directed and random requests into the allocator and checks every result.
module tb_size_class_block_allocator_top;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] size;
    logic [17:0] addr;
    bit          typed;
    logic [1:0]  st;
    logic [17:0] blk;
    logic [11:0] usable;
  } row_t;

  typedef struct {
    logic [1:0]  st;
    logic [17:0] blk;
    logic [11:0] usable;
  } outcome_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1530;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [15:0] req_size;
  logic [17:0] address;
  logic        done;
  logic [1:0]  status;
  logic [17:0] block_address;
  logic [11:0] usable_bytes;

  int unsigned list_head[scba_pkg::NUM_CLASSES];
  int unsigned unit_link[scba_pkg::TOTAL_UNITS];
  logic [3:0]  page_tag[scba_pkg::POOL_PAGES];
  int unsigned fresh_page;

  outcome_t    pending_results[$];
  logic [17:0] live_blocks[$];
  int          errors;
  int          cycles;
  bit          quiet;

  size_class_block_allocator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .req_size(req_size), .address(address), .done(done), .status(status),
    .block_address(block_address), .usable_bytes(usable_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic outcome_t allocate_or_lookup(logic [1:0] f, logic [15:0] s,
                                                  logic [17:0] a);
    outcome_t    o;
    int unsigned c, bs, pg, slots, step, base, u, slot;
    o = '{scba_pkg::STATUS_OK, '0, '0};
    if (f == scba_pkg::FUNC_ALLOC) begin
      c = 0;
      while (c < scba_pkg::NUM_CLASSES && (scba_pkg::MIN_BLOCK_BYTES << c) < s) c++;
      if (s == 0 || c >= scba_pkg::NUM_CLASSES) begin
        o.st = scba_pkg::STATUS_UNSUP;
      end else begin
        if (list_head[c] == 0) begin
          if (fresh_page >= scba_pkg::POOL_PAGES) begin
            o.st = scba_pkg::STATUS_EXHAUSTED;
          end else begin
            step = 1 << c;
            slots = scba_pkg::PAGE_BYTES / (scba_pkg::MIN_BLOCK_BYTES << c);
            base = fresh_page * scba_pkg::UNITS_PER_PAGE;
            page_tag[fresh_page] = {1'b1, 3'(c)};
            for (int k = 1; k < slots; k++)
              unit_link[base + k * step] = (k + 1 < slots) ? base + (k + 1) * step + 1 : 0;
            list_head[c] = (slots > 1) ? base + step + 1 : 0;
            fresh_page++;
          end
        end
        if (o.st == scba_pkg::STATUS_OK && list_head[c] != 0) begin
          u = list_head[c] - 1;
          list_head[c] = unit_link[u];
          o.blk = 18'(u * scba_pkg::MIN_BLOCK_BYTES);
        end else if (o.st == scba_pkg::STATUS_OK) begin
          o.st = scba_pkg::STATUS_EXHAUSTED;
        end
      end
    end else if (f == scba_pkg::FUNC_FREE || f == scba_pkg::FUNC_QUERY) begin
      pg = a / scba_pkg::PAGE_BYTES;
      if (pg >= fresh_page || !page_tag[pg][3]) begin
        o.st = scba_pkg::STATUS_UNMANAGED;
      end else begin
        c = page_tag[pg][2:0];
        bs = scba_pkg::MIN_BLOCK_BYTES << c;
        if (f == scba_pkg::FUNC_QUERY) begin
          o.usable = 12'(bs);
        end else begin
          slot = (a % scba_pkg::PAGE_BYTES) / bs;
          if (slot == 0) begin
            o.st = scba_pkg::STATUS_UNMANAGED;
          end else begin
            u = pg * scba_pkg::UNITS_PER_PAGE + slot * (bs / scba_pkg::MIN_BLOCK_BYTES);
            unit_link[u] = list_head[c];
            list_head[c] = u + 1;
          end
        end
      end
    end else begin
      o.st = scba_pkg::STATUS_UNSUP;
    end
    return o;
  endfunction

  task automatic issue(row_t r);
    outcome_t o;
    start = 1'b1;
    func = r.func;
    req_size = r.size;
    address = r.addr;
    do @(posedge clk); while (busy);
    o = allocate_or_lookup(r.func, r.size, r.addr);
    if (r.func == scba_pkg::FUNC_ALLOC && o.st == scba_pkg::STATUS_OK)
      live_blocks.push_back(o.blk);
    if (r.typed) o = '{r.st, r.blk, r.usable};
    pending_results.push_back(o);
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer status=%0d block=%0h usable=%0d", $time,
                 status, block_address, usable_bytes);
        errors++;
      end else begin
        outcome_t e;
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (block_address !== e.blk) begin
          $display("%0t: block_address expected %0h actual %0h", $time, e.blk,
                   block_address);
          errors++;
        end
        if (usable_bytes !== e.usable) begin
          $display("%0t: usable_bytes expected %0d actual %0d", $time, e.usable,
                   usable_bytes);
          errors++;
        end
      end
    end
  end

  row_t directed[] = '{
    '{scba_pkg::FUNC_QUERY, 16'd0, 18'd0, 1, scba_pkg::STATUS_UNMANAGED, 18'd0, 12'd0},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd0, 1, scba_pkg::STATUS_UNMANAGED, 18'd0, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd0, 18'd0, 1, scba_pkg::STATUS_UNSUP, 18'd0, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd2049, 18'd0, 1, scba_pkg::STATUS_UNSUP, 18'd0, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'hFFFF, 18'h3FFFF, 1, scba_pkg::STATUS_UNSUP, 18'd0, 12'd0},
    '{2'd3, 16'hFFFF, 18'h3FFFF, 1, scba_pkg::STATUS_UNSUP, 18'd0, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd1, 18'd0, 1, scba_pkg::STATUS_OK, 18'd16, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd16, 18'd0, 1, scba_pkg::STATUS_OK, 18'd32, 12'd0},
    '{scba_pkg::FUNC_QUERY, 16'd0, 18'd0, 1, scba_pkg::STATUS_OK, 18'd0, 12'd16},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd8, 1, scba_pkg::STATUS_UNMANAGED, 18'd0, 12'd0},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd40, 0, 0, 0, 0},
    '{scba_pkg::FUNC_ALLOC, 16'd5, 18'd0, 0, 0, 0, 0},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd40, 0, 0, 0, 0},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd40, 0, 0, 0, 0},
    '{scba_pkg::FUNC_ALLOC, 16'd17, 18'd0, 1, scba_pkg::STATUS_OK, 18'd4128, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd2048, 18'd0, 1, scba_pkg::STATUS_OK, 18'd10240, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd2048, 18'd0, 1, scba_pkg::STATUS_OK, 18'd14336, 12'd0},
    '{scba_pkg::FUNC_ALLOC, 16'd2048, 18'd0, 0, 0, 0, 0},
    '{scba_pkg::FUNC_QUERY, 16'd0, 18'd8191, 0, 0, 0, 0},
    '{scba_pkg::FUNC_QUERY, 16'd0, 18'h3FFFF, 1, scba_pkg::STATUS_UNMANAGED, 18'd0, 12'd0},
    '{scba_pkg::FUNC_FREE, 16'd0, 18'd10240, 0, 0, 0, 0},
    '{scba_pkg::FUNC_ALLOC, 16'd1025, 18'd0, 0, 0, 0, 0},
    '{scba_pkg::FUNC_ALLOC, 16'd600, 18'd0, 0, 0, 0, 0},
    '{scba_pkg::FUNC_QUERY, 16'd0, 18'd20000, 0, 0, 0, 0}
  };

  initial begin
    row_t r;
    int   pick;
    rst = 1'b1;
    start = 1'b0;
    func = '0;
    req_size = '0;
    address = '0;
    errors = 0;
    cycles = 0;
    quiet = 0;
    foreach (list_head[i]) list_head[i] = 0;
    foreach (unit_link[i]) unit_link[i] = 0;
    foreach (page_tag[i]) page_tag[i] = '0;
    fresh_page = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) begin
      issue(directed[i]);
      maybe_idle();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n > RANDOM_ITEMS - 300);
      r = '{2'd0, 16'd0, 18'd0, 0, 2'd0, 18'd0, 12'd0};
      pick = $urandom_range(99);
      if (pick < 45) begin
        r.func = scba_pkg::FUNC_ALLOC;
        case ($urandom_range(9))
          0: r.size = 16'($urandom_range(65535));
          1: r.size = 16'($urandom_range(1)) ? 16'd0 : 16'($urandom_range(65535, 2049));
          default: r.size = 16'(scba_pkg::MIN_BLOCK_BYTES << $urandom_range(7)) -
                            16'($urandom_range(1) ? 0 : 1);
        endcase
        if (r.size == 16'd2048 && $urandom_range(2) != 0) r.size = 16'd100;
      end else if (pick < 80) begin
        r.func = scba_pkg::FUNC_FREE;
        if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
          int k;
          k = $urandom_range(live_blocks.size() - 1);
          r.addr = live_blocks[k] | 18'($urandom_range(1) ? 0 : $urandom_range(15));
          live_blocks.delete(k);
        end else begin
          r.addr = 18'($urandom);
        end
      end else if (pick < 95) begin
        r.func = scba_pkg::FUNC_QUERY;
        r.addr = (live_blocks.size() > 0 && $urandom_range(1)) ?
                 live_blocks[$urandom_range(live_blocks.size() - 1)] : 18'($urandom);
      end else begin
        r.func = 2'd3;
        r.size = 16'($urandom);
        r.addr = 18'($urandom);
      end
      issue(r);
      maybe_idle();
    end
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
